### hw/rtl/atvp_pkg.sv
// ----------------------------------------------------------------------------
// Arc trapezoid velocity profile package
// Shared widths, register indexes, transaction and operation codes and reset values.
// ----------------------------------------------------------------------------
package atvp_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned WIDE_W = 64;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD  = 2'd2;

  // Input transaction kinds carried on tuser.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_NEXT  = 1'b1;

  // Operations of the shared shift-subtract unit.
  localparam logic OP_SQRT = 1'b0;
  localparam logic OP_DIV  = 1'b1;

  // Register reset values.
  localparam logic [DATA_W-1:0] VELOCITY_LIMIT_RST = 32'd6553600;
  localparam logic [DATA_W-1:0] ACCEL_LIMIT_RST    = 32'd65536000;
  localparam logic [DATA_W-1:0] SAMPLE_PERIOD_RST  = 32'd16777;

endpackage

### hw/rtl/arc_trapezoid_velocity_profile.sv
// ----------------------------------------------------------------------------
// Arc trapezoid velocity profile generator
// Plans a trapezoidal or triangular velocity profile along an arc and emits
// one velocity sample per next transaction.
// ----------------------------------------------------------------------------
// A start transaction holds the block through up to two 64-step divisions, one or two
// 32-step roots (the second for a triangular profile) and registered multiplies.
// A next transaction runs a 64-step division for its position and, on a ramp, a second
// one for its velocity; with no active profile it goes straight to the output.
// Throughput: one transaction at a time, set by the single shared shift-subtract unit.
// Reset (rst, synchronous) restores the register defaults and drops any profile.
module arc_trapezoid_velocity_profile #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [atvp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [atvp_pkg::DATA_W-1:0]   cfg_data,
  // Input stream.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [63:0]                   s_tdata,   // [31:0] radius, [63:32] sweep angle
  input  logic                          s_tuser,   // [0] action
  // Output stream.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [47:0]                   m_tdata,   // [31:0] velocity, [47:32] sample_number
  output logic                          m_tlast,   // last_sample
  output logic [1:0]                    m_tuser    // [0] saturated, [1] no_arc
);
  import atvp_pkg::*;

  localparam logic [WIDE_W-1:0] MAX_COUNT = (64'd1 << COUNT_BITS) - 64'd1;

  // Sequencer state codes.
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_LEN    = 5'd1;
  localparam logic [4:0] S_CENT   = 5'd2;
  localparam logic [4:0] S_CENT_W = 5'd3;
  localparam logic [4:0] S_STEP   = 5'd4;
  localparam logic [4:0] S_CNT    = 5'd5;
  localparam logic [4:0] S_CNT_W  = 5'd6;
  localparam logic [4:0] S_RSQ    = 5'd7;
  localparam logic [4:0] S_RAMP   = 5'd8;
  localparam logic [4:0] S_RAMP_W = 5'd9;
  localparam logic [4:0] S_MODE   = 5'd10;
  localparam logic [4:0] S_PEAK   = 5'd11;
  localparam logic [4:0] S_PEAK_W = 5'd12;
  localparam logic [4:0] S_POS    = 5'd13;
  localparam logic [4:0] S_POS_W  = 5'd14;
  localparam logic [4:0] S_SC     = 5'd15;
  localparam logic [4:0] S_SC_W   = 5'd16;
  localparam logic [4:0] S_EMIT   = 5'd17;

  logic [4:0] state;

  // Configuration registers.
  logic [DATA_W-1:0] velocity_limit;
  logic [DATA_W-1:0] accel_limit;
  logic [DATA_W-1:0] sample_period;

  // Profile state.
  logic                  profile_active;
  logic [COUNT_BITS-1:0] total_samples;
  logic [COUNT_BITS-1:0] current_sample;
  logic [DATA_W-1:0]     path_length;
  logic [DATA_W-1:0]     ramp_distance;
  logic [DATA_W-1:0]     plateau_distance;
  logic [DATA_W-1:0]     top_velocity;
  logic                  triangle_mode;
  logic                  clip_flag;

  // Working registers of the planner.
  logic [DATA_W-1:0] radius;
  logic [DATA_W-1:0] speed;
  logic [WIDE_W-1:0] ramp_full;
  logic [WIDE_W-1:0] prod;

  // Pending result, waiting for the output register.
  logic [DATA_W-1:0]     res_vel;
  logic [COUNT_BITS-1:0] res_idx;
  logic                  res_last;
  logic                  res_sat;
  logic                  res_noarc;

  // Shared shift-subtract unit: restoring division and digit-by-digit root.
  logic              u_busy;
  logic              u_op;
  logic [6:0]        u_cnt;
  logic [WIDE_W-1:0] u_acc;
  logic [WIDE_W-1:0] u_rem;
  logic [WIDE_W-1:0] u_den;
  logic [DATA_W-1:0] u_root;
  logic [65:0]       u_trial;
  logic [65:0]       u_sub;
  logic [65:0]       u_diff;
  logic              u_ge;
  logic [WIDE_W-1:0] u_res;
  logic              u_start;
  logic              u_start_op;
  logic [WIDE_W-1:0] u_start_num;
  logic [WIDE_W-1:0] u_start_den;

  logic [DATA_W-1:0] in_radius;
  logic [DATA_W-1:0] in_span;
  logic [DATA_W-1:0] span_abs;
  logic              in_fire;
  logic              out_free;

  logic [COUNT_BITS-1:0] last_idx;
  logic [COUNT_BITS-1:0] idx_sel;
  logic [DATA_W-1:0]     mul_a;
  logic [DATA_W-1:0]     mul_b;
  logic                  mul_en;

  // Sample position decode.
  logic [DATA_W-1:0] pos;
  logic [DATA_W:0]   plat_end;
  logic [DATA_W-1:0] tail;
  logic [DATA_W-1:0] tail_clamp;
  logic [DATA_W-1:0] scale_x;
  logic              vel_flat;

  logic [DATA_W-1:0] idx_wide;

  assign in_radius = s_tdata[31:0];
  assign in_span   = s_tdata[63:32];
  assign span_abs  = in_span[31] ? (~in_span + 32'd1) : in_span;
  assign s_tready  = (state == S_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign last_idx = total_samples - {{(COUNT_BITS-1){1'b0}}, 1'b1};
  assign idx_sel  = (current_sample > last_idx) ? last_idx : current_sample;

  // The shared multiplier; its product is always registered before use.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    unique case (state)
      S_IDLE: begin
        mul_en = in_fire;
        if (s_tuser == ACT_START) begin
          mul_a = in_radius;
          mul_b = span_abs;
        end else begin
          mul_a = path_length;
          mul_b = DATA_W'(idx_sel);
        end
      end
      S_LEN: begin
        mul_en = 1'b1;
        mul_a  = accel_limit;
        mul_b  = radius;
      end
      S_STEP: begin
        mul_en = 1'b1;
        mul_a  = speed;
        mul_b  = sample_period;
      end
      S_RSQ: begin
        mul_en = 1'b1;
        mul_a  = speed;
        mul_b  = speed;
      end
      S_MODE: begin
        mul_en = 1'b1;
        mul_a  = accel_limit;
        mul_b  = path_length;
      end
      S_POS_W: begin
        mul_en = !u_busy;
        mul_a  = top_velocity;
        mul_b  = scale_x;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Requests to the shared unit.
  always_comb begin
    u_start     = 1'b0;
    u_start_op  = OP_DIV;
    u_start_num = prod;
    u_start_den = prod;
    unique case (state)
      S_CENT, S_PEAK: begin
        u_start    = 1'b1;
        u_start_op = OP_SQRT;
      end
      S_CNT: begin
        u_start     = (prod != '0);
        u_start_num = {8'd0, path_length, 24'd0};
        u_start_den = prod;
      end
      S_RAMP: begin
        u_start     = (accel_limit != '0);
        u_start_den = {31'd0, accel_limit, 1'b0};
      end
      S_POS: begin
        u_start     = 1'b1;
        u_start_den = WIDE_W'(last_idx);
      end
      S_SC: begin
        u_start     = 1'b1;
        u_start_den = {32'd0, ramp_distance};
      end
      default: begin
        u_start = 1'b0;
      end
    endcase
  end

  // One step of the shared unit: a single compare and subtract.
  always_comb begin
    if (u_op == OP_DIV) begin
      u_trial = {1'b0, u_rem, u_acc[63]};
      u_sub   = {2'b00, u_den};
    end else begin
      u_trial = {31'd0, u_rem[32:0], u_acc[63:62]};
      u_sub   = {32'd0, u_root, 2'b01};
    end
    u_diff = u_trial - u_sub;
    u_ge   = !u_diff[65];
    u_res  = (u_op == OP_DIV) ? u_acc : {32'd0, u_root};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u_busy <= 1'b0;
    end else if (u_start) begin
      u_busy <= 1'b1;
    end else if (u_busy && u_cnt == 7'd1) begin
      u_busy <= 1'b0;
    end
    if (u_start) begin
      u_op   <= u_start_op;
      u_cnt  <= (u_start_op == OP_DIV) ? 7'd64 : 7'd32;
      u_acc  <= u_start_num;
      u_den  <= u_start_den;
      u_rem  <= '0;
      u_root <= '0;
    end else if (u_busy) begin
      u_cnt <= u_cnt - 7'd1;
      u_rem <= u_ge ? u_diff[63:0] : u_trial[63:0];
      if (u_op == OP_DIV) begin
        u_acc <= {u_acc[62:0], u_ge};
      end else begin
        u_acc  <= {u_acc[61:0], 2'b00};
        u_root <= {u_root[30:0], u_ge};
      end
    end
  end

  // Where the sample lies: rising ramp, plateau or falling ramp.
  always_comb begin
    pos        = u_res[31:0];
    plat_end   = {1'b0, ramp_distance} + {1'b0, plateau_distance};
    tail       = pos - ramp_distance - plateau_distance;
    tail_clamp = (tail > ramp_distance) ? ramp_distance : tail;
    vel_flat   = 1'b0;
    if (pos <= ramp_distance) begin
      scale_x = pos;
    end else if (triangle_mode) begin
      scale_x = path_length - pos;
    end else if ({1'b0, pos} <= plat_end) begin
      scale_x  = pos;
      vel_flat = 1'b1;
    end else begin
      scale_x = ramp_distance - tail_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= WIDE_W'(mul_a) * WIDE_W'(mul_b);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_limit <= VELOCITY_LIMIT_RST;
      accel_limit    <= ACCEL_LIMIT_RST;
      sample_period  <= SAMPLE_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VELOCITY_LIMIT: velocity_limit <= cfg_data;
        CFG_ACCEL_LIMIT:    accel_limit    <= cfg_data;
        CFG_SAMPLE_PERIOD:  sample_period  <= cfg_data;
        default:            velocity_limit <= velocity_limit;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      profile_active   <= 1'b0;
      total_samples    <= '0;
      current_sample   <= '0;
      path_length      <= '0;
      ramp_distance    <= '0;
      plateau_distance <= '0;
      top_velocity     <= '0;
      triangle_mode    <= 1'b0;
      clip_flag        <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      // The emit state reloads the output register itself.
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (s_tuser == ACT_START) begin
              radius         <= in_radius;
              profile_active <= 1'b0;
              state          <= S_LEN;
            end else if (!profile_active || total_samples < COUNT_BITS'(2)) begin
              // A request with no profile gives a flagged zero sample.
              profile_active <= 1'b0;
              res_vel        <= '0;
              res_idx        <= '0;
              res_last       <= 1'b0;
              res_sat        <= 1'b0;
              res_noarc      <= 1'b1;
              state          <= S_EMIT;
            end else begin
              res_idx   <= idx_sel;
              res_last  <= (idx_sel == last_idx);
              res_sat   <= clip_flag;
              res_noarc <= 1'b0;
              state     <= S_POS;
            end
          end
        end
        S_LEN: begin
          // Arc length is Q20.44 here; an integer part wider than 16 bits clips.
          if (prod[63:60] != 4'd0) begin
            path_length <= '1;
            clip_flag   <= 1'b1;
          end else begin
            path_length <= prod[59:28];
            clip_flag   <= 1'b0;
          end
          state <= S_CENT;
        end
        S_CENT: begin
          state <= S_CENT_W;
        end
        S_CENT_W: begin
          if (!u_busy) begin
            speed <= (velocity_limit < u_res[31:0]) ? velocity_limit : u_res[31:0];
            state <= S_STEP;
          end
        end
        S_STEP: begin
          state <= S_CNT;
        end
        S_CNT: begin
          if (prod == '0) begin
            total_samples <= MAX_COUNT[COUNT_BITS-1:0];
            clip_flag     <= 1'b1;
            state         <= S_RSQ;
          end else begin
            state <= S_CNT_W;
          end
        end
        S_CNT_W: begin
          if (!u_busy) begin
            if (u_res >= MAX_COUNT) begin
              total_samples <= MAX_COUNT[COUNT_BITS-1:0];
              clip_flag     <= 1'b1;
            end else if (u_res == '0) begin
              total_samples <= COUNT_BITS'(2);
            end else begin
              total_samples <= u_res[COUNT_BITS-1:0] + {{(COUNT_BITS-1){1'b0}}, 1'b1};
            end
            state <= S_RSQ;
          end
        end
        S_RSQ: begin
          state <= S_RAMP;
        end
        S_RAMP: begin
          if (accel_limit == '0) begin
            ramp_full <= '0;
            state     <= S_MODE;
          end else begin
            state <= S_RAMP_W;
          end
        end
        S_RAMP_W: begin
          if (!u_busy) begin
            ramp_full <= u_res;
            state     <= S_MODE;
          end
        end
        S_MODE: begin
          if ({ramp_full, 1'b0} > {33'd0, path_length}) begin
            // The two ramps do not fit: triangular profile.
            triangle_mode    <= 1'b1;
            ramp_distance    <= {1'b0, path_length[31:1]};
            plateau_distance <= '0;
            state            <= S_PEAK;
          end else begin
            triangle_mode    <= 1'b0;
            top_velocity     <= speed;
            ramp_distance    <= ramp_full[31:0];
            plateau_distance <= path_length - {ramp_full[30:0], 1'b0};
            current_sample   <= '0;
            profile_active   <= 1'b1;
            state            <= S_IDLE;
          end
        end
        S_PEAK: begin
          state <= S_PEAK_W;
        end
        S_PEAK_W: begin
          if (!u_busy) begin
            top_velocity   <= (u_res[31:0] < speed) ? u_res[31:0] : speed;
            current_sample <= '0;
            profile_active <= 1'b1;
            state          <= S_IDLE;
          end
        end
        S_POS: begin
          state <= S_POS_W;
        end
        S_POS_W: begin
          if (!u_busy) begin
            if (vel_flat) begin
              res_vel <= top_velocity;
              state   <= S_EMIT;
            end else if (ramp_distance == '0) begin
              res_vel <= '0;
              state   <= S_EMIT;
            end else begin
              state <= S_SC;
            end
          end
        end
        S_SC: begin
          state <= S_SC_W;
        end
        S_SC_W: begin
          if (!u_busy) begin
            res_vel <= u_res[31:0];
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {idx_wide[15:0], res_vel};
            m_tlast  <= res_last;
            m_tuser  <= {res_noarc, res_sat};
            if (!res_noarc) begin
              if (res_last) begin
                profile_active <= 1'b0;
              end else begin
                current_sample <= res_idx + {{(COUNT_BITS-1){1'b0}}, 1'b1};
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idx_wide = DATA_W'(res_idx);

  // The shared unit only runs while the sequencer waits on it.
  a_unit_owned: assert property (@(posedge clk) disable iff (rst)
    u_busy |-> (state == S_CENT_W || state == S_CNT_W || state == S_RAMP_W ||
                state == S_PEAK_W || state == S_POS_W || state == S_SC_W))
    else $error("shared unit busy outside a wait state");

  // An active profile always has at least two samples.
  a_count_min: assert property (@(posedge clk) disable iff (rst)
    profile_active |-> total_samples >= COUNT_BITS'(2))
    else $error("active profile with fewer than two samples");

  // The sample index never runs past the final sample.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    profile_active |-> current_sample <= last_idx)
    else $error("sample index beyond profile");

  // A no-profile result carries zero velocity and no last flag.
  a_noarc_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tdata == '0 && !m_tlast && !m_tuser[0]))
    else $error("no-profile result with non-zero fields");

endmodule
